/* design/mtk_pkg.sv */
`timescale 1ns / 1ps

package mtk_pkg;

    // Action codes carried by an input item
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_PHRASE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS    = 1'b0;
    localparam logic CFG_CARRIER_TICKS = 1'b1;

    // Character codes used by the lookup
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    localparam int CODE_COUNT = 36;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
    } in_t;

    typedef struct packed {
        logic buzzer;
        logic busy_res;
        logic rejected;
    } out_t;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [7:0]  carrier_ticks;
    } cfg_t;

    // Result of a character lookup: element count and pattern (bit 0 first, 1 = dash)
    typedef struct packed {
        logic       hit;
        logic [2:0] count;
        logic [4:0] pattern;
    } code_t;

    // {count, pattern}: digits 0-9, then letters A-Z
    localparam logic [7:0] CODE_TABLE [0:CODE_COUNT-1] = '{
        {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
        {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
        {3'd5, 5'b00111}, {3'd5, 5'b01111},
        {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
        {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
        {3'd4, 5'b01101}, {3'd4, 5'b00011}
    };

    // Map a character to its Morse code; hit is low for codes outside the table
    function automatic code_t char_code(input logic [7:0] ch);
        code_t      c;
        logic [7:0] off;
        logic [7:0] entry;
        begin
            c     = '0;
            off   = '0;
            entry = '0;
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                off   = ch - CH_ZERO;
                c.hit = 1'b1;
            end
            else if (ch >= CH_A && ch <= CH_Z)
            begin
                off   = ch - CH_A + LETTER_BASE;
                c.hit = 1'b1;
            end
            if (c.hit)
            begin
                entry     = CODE_TABLE[off[5:0]];
                c.count   = entry[7:5];
                c.pattern = entry[4:0];
            end
            return c;
        end
    endfunction

endpackage

/* design/mtk_in_stage.sv */
`timescale 1ns / 1ps

module mtk_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  mtk_pkg::in_t item,
    input  logic         room,
    output logic         hold_valid,
    output mtk_pkg::in_t hold
);
    import mtk_pkg::*;

    logic vld_reg;
    in_t  data_reg;
    logic take;
    logic drain;

    // Beat leaves when the result side has room; a new beat may enter the same cycle
    assign drain      = vld_reg & room;
    assign item_stall = vld_reg & ~room;
    assign take       = item_valid & ~item_stall;
    assign hold_valid = vld_reg;
    assign hold       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (drain)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= item;
        end
    end

endmodule

/* design/mtk_keyer_core.sv */
`timescale 1ns / 1ps

module mtk_keyer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  mtk_pkg::in_t  item,
    input  mtk_pkg::cfg_t cfg,
    output mtk_pkg::out_t res
);
    import mtk_pkg::*;

    localparam logic [2:0] SEG_IDLE     = 3'd0;
    localparam logic [2:0] SEG_DOT      = 3'd1;
    localparam logic [2:0] SEG_DASH     = 3'd2;
    localparam logic [2:0] SEG_ELEM_GAP = 3'd3;
    localparam logic [2:0] SEG_CHAR_GAP = 3'd4;
    localparam logic [2:0] SEG_WORD_GAP = 3'd5;

    logic [2:0]  seg_reg,     seg_next;
    logic [18:0] elapsed_reg, elapsed_next;
    logic [7:0]  carrier_reg, carrier_next;
    logic        phase_reg,   phase_next;
    logic [4:0]  pattern_reg, pattern_next;
    logic [2:0]  left_reg,    left_next;
    logic        pending_reg, pending_next;
    logic        buzzer_reg,  buzzer_next;

    logic [18:0] unit;
    logic [18:0] seg_len;
    logic [7:0]  period;
    logic [18:0] elapsed_inc;
    logic [7:0]  carrier_inc;
    logic        is_tone;
    logic        busy;
    logic        rej;
    logic        seg_end;
    logic        do_tone;
    logic        do_start;
    logic [2:0]  start_kind;
    code_t       code;

    // Segment length from the unit register; zero counts as one
    assign unit   = (cfg.unit_ticks == '0) ? 19'd1 : {3'b000, cfg.unit_ticks};
    assign period = (cfg.carrier_ticks == '0) ? 8'd1 : cfg.carrier_ticks;

    always_comb
    begin
        unique case (seg_reg) inside
            SEG_DASH, SEG_CHAR_GAP: seg_len = unit + {unit[17:0], 1'b0};
            SEG_WORD_GAP:           seg_len = {unit[15:0], 3'b000} - unit;
            default:                seg_len = unit;
        endcase
    end

    assign is_tone     = (seg_reg == SEG_DOT) || (seg_reg == SEG_DASH);
    assign busy        = seg_reg != SEG_IDLE;
    assign elapsed_inc = elapsed_reg + 19'd1;
    assign carrier_inc = carrier_reg + 8'd1;
    assign code        = char_code(item.character);

    // Next state for one item
    always_comb
    begin
        seg_next     = seg_reg;
        elapsed_next = elapsed_reg;
        carrier_next = carrier_reg;
        phase_next   = phase_reg;
        pattern_next = pattern_reg;
        left_next    = left_reg;
        pending_next = pending_reg;
        buzzer_next  = buzzer_reg;
        rej          = 1'b0;
        seg_end      = 1'b0;
        do_tone      = 1'b0;
        do_start     = 1'b0;
        start_kind   = SEG_IDLE;

        unique case (item.action)
            ACT_TICK:
            begin
                if (busy)
                begin
                    elapsed_next = elapsed_inc;
                    if (is_tone)
                    begin
                        if (carrier_inc >= period)
                        begin
                            carrier_next = '0;
                            if (elapsed_inc >= seg_len)
                            begin
                                buzzer_next = 1'b0;
                                seg_end     = 1'b1;
                            end
                            else
                            begin
                                buzzer_next = ~phase_reg;
                                phase_next  = ~phase_reg;
                            end
                        end
                        else
                        begin
                            carrier_next = carrier_inc;
                        end
                    end
                    else if (elapsed_inc >= seg_len)
                    begin
                        seg_end = 1'b1;
                    end
                end
            end
            ACT_LOAD:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else if (item.character == CH_SPACE)
                begin
                    left_next    = '0;
                    pattern_next = '0;
                    pending_next = 1'b1;
                    do_start     = 1'b1;
                    start_kind   = SEG_WORD_GAP;
                end
                else if (code.hit)
                begin
                    pattern_next = code.pattern;
                    left_next    = code.count;
                    pending_next = 1'b1;
                    do_tone      = 1'b1;
                end
            end
            ACT_PHRASE:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    left_next    = '0;
                    pattern_next = '0;
                    pending_next = 1'b0;
                    do_start     = 1'b1;
                    start_kind   = SEG_WORD_GAP;
                end
            end
            default:
            begin
            end
        endcase

        // Segment sequencing at the end of a segment
        if (seg_end)
        begin
            if (is_tone)
            begin
                do_start   = 1'b1;
                start_kind = SEG_ELEM_GAP;
            end
            else if (left_reg != '0)
            begin
                do_tone = 1'b1;
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                do_start     = 1'b1;
                start_kind   = SEG_CHAR_GAP;
            end
            else
            begin
                do_start   = 1'b1;
                start_kind = SEG_IDLE;
            end
        end

        // Pop the next element
        if (do_tone)
        begin
            start_kind   = pattern_next[0] ? SEG_DASH : SEG_DOT;
            pattern_next = {1'b0, pattern_next[4:1]};
            left_next    = left_next - 3'd1;
            do_start     = 1'b1;
        end

        // Fresh segment: counters clear, buzzer off
        if (do_start)
        begin
            seg_next     = start_kind;
            elapsed_next = '0;
            carrier_next = '0;
            phase_next   = 1'b0;
            buzzer_next  = 1'b0;
        end
    end

    assign res.buzzer   = buzzer_next;
    assign res.busy_res = seg_next != SEG_IDLE;
    assign res.rejected = rej;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg     <= SEG_IDLE;
            elapsed_reg <= '0;
            carrier_reg <= '0;
            phase_reg   <= 1'b0;
            pattern_reg <= '0;
            left_reg    <= '0;
            pending_reg <= 1'b0;
            buzzer_reg  <= 1'b0;
        end
        else if (en)
        begin
            seg_reg     <= seg_next;
            elapsed_reg <= elapsed_next;
            carrier_reg <= carrier_next;
            phase_reg   <= phase_next;
            pattern_reg <= pattern_next;
            left_reg    <= left_next;
            pending_reg <= pending_next;
            buzzer_reg  <= buzzer_next;
        end
    end

endmodule

/* design/mtk_out_stage.sv */
`timescale 1ns / 1ps

module mtk_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  mtk_pkg::out_t res,
    output logic          room,
    output logic          result_valid,
    input  logic          result_stall,
    output mtk_pkg::out_t result
);
    import mtk_pkg::*;

    logic vld_reg;
    out_t data_reg;

    // Room when empty or when the held beat leaves this cycle
    assign room         = ~vld_reg | ~result_stall;
    assign result_valid = vld_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (room)
        begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

/* design/morse_tone_keyer_unit.sv */
`timescale 1ns / 1ps

// Morse tone keyer. Each input beat is a tick, a character load (space, 0-9, A-Z)
// or an end-of-phrase, and each beat returns one result beat with the buzzer level,
// busy and a reject flag. Loads are taken only while idle; a load or end-of-phrase
// while busy is flagged as rejected. One beat is accepted every clock cycle unless the
// result side stalls; a beat is held in the input register, then passes through the
// keyer state update into the result register. Throughput is set by the keyer state
// update. Config registers (index 0 unit_ticks, 1 carrier_ticks) are always ready;
// write them only while no beat is in flight. A write takes effect at once, even in
// the middle of a character.
module morse_tone_keyer_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  mtk_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output mtk_pkg::out_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);
    import mtk_pkg::*;

    logic [15:0] unit_ticks_reg;
    logic [7:0]  carrier_ticks_reg;
    cfg_t        cfg;
    logic        room;
    logic        hold_valid;
    in_t         hold;
    logic        step;
    out_t        res;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg    <= 16'd100;
            carrier_ticks_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_UNIT_TICKS:    unit_ticks_reg    <= cfg_data;
                CFG_CARRIER_TICKS: carrier_ticks_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.unit_ticks    = unit_ticks_reg;
    assign cfg.carrier_ticks = carrier_ticks_reg;

    // Item moves from input register through the core into the result register
    assign step = hold_valid & room;

    mtk_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .room       (room),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    mtk_keyer_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .item  (hold),
        .cfg   (cfg),
        .res   (res)
    );

    mtk_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .res          (res),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* design/mtk_checker.sv */
`timescale 1ns / 1ps

module mtk_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_stall,
    input logic          result_valid,
    input logic          result_stall,
    input mtk_pkg::out_t result
);
    import mtk_pkg::*;

    // Stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // A rejected beat only happens while the keyer is busy
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rejected |-> result.busy_res)
        else $error("reject reported while idle");

    // Idle keyer never drives the buzzer
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.busy_res |-> !result.buzzer)
        else $error("buzzer on while idle");

    // A fresh result beat comes from an input beat that passed through the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("result beat without an input beat");

endmodule

bind morse_tone_keyer_unit mtk_checker u_mtk_checker (.*);

/* dv/morse_tone_keyer_unit_tb.sv */
`timescale 1ns / 1ps

module morse_tone_keyer_unit_tb;

    import mtk_pkg::*;

    // Action code 3 has no meaning; the keyer must ignore it
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam int PIPE_LATENCY   = 2;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int REPORT_LIMIT   = 10;

    // Segment being keyed, as the predictor tracks it
    typedef enum logic [2:0] {
        KEY_IDLE,
        KEY_DOT,
        KEY_DASH,
        KEY_MARK_GAP,
        KEY_LETTER_GAP,
        KEY_WORD_GAP
    } key_seg_t;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    logic  item_stall;
    in_t   item         = '0;
    logic  result_valid;
    logic  result_stall = 1'b0;
    out_t  result;
    logic  cfg_valid    = 1'b0;
    logic  cfg_ready;
    logic  cfg_index    = CFG_UNIT_TICKS;
    logic [15:0] cfg_data = '0;

    // Predicted keyer state and register copies
    key_seg_t    seg_now;
    logic [18:0] seg_ticks;
    logic [7:0]  half_count;
    logic        tone_on_next;
    logic [4:0]  marks_queued;   // bit 0 goes first, 1 = dash
    logic [2:0]  marks_left;
    logic        letter_gap_due;
    logic        buzz_level;
    logic [15:0] unit_setting;
    logic [7:0]  carrier_setting;

    out_t        expected_beats [$];
    int unsigned keyed_beats  = 0;
    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;

    // Pacing controls shared by the test tasks and the result sink
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;

    // Dot/dash text for 0-9 then A-Z
    string morse_table [0:35] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----.",
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--.."
    };

    morse_tone_keyer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic bit morse_lookup(input logic [7:0] ch, output logic [2:0] len,
                                        output logic [4:0] dashes);
        string s;
        len    = '0;
        dashes = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            s = morse_table[int'(ch - CH_ZERO)];
        else if (ch >= CH_A && ch <= CH_Z)
            s = morse_table[int'(ch - CH_A) + 10];
        else
            return 1'b0;
        for (int n = 0; n < s.len(); n++)
        begin
            if (s[n] == "-")
                dashes[n] = 1'b1;
        end
        len = 3'(s.len());
        return 1'b1;
    endfunction

    function automatic bit is_keyable(input logic [7:0] ch);
        logic [2:0] len;
        logic [4:0] dashes;
        return ch == CH_SPACE || morse_lookup(ch, len, dashes);
    endfunction

    // Segment length in ticks; a zero unit counts as one
    function automatic int unsigned span_ticks(input key_seg_t s);
        int unsigned u;
        u = (unit_setting == 0) ? 1 : unit_setting;
        if (s == KEY_DASH || s == KEY_LETTER_GAP)
            return 3 * u;
        if (s == KEY_WORD_GAP)
            return 7 * u;
        return u;
    endfunction

    function automatic void open_segment(input key_seg_t s);
        seg_now      = s;
        seg_ticks    = '0;
        half_count   = '0;
        tone_on_next = 1'b1;
        buzz_level   = 1'b0;
    endfunction

    function automatic void next_mark();
        key_seg_t kind;
        kind         = marks_queued[0] ? KEY_DASH : KEY_DOT;
        marks_queued = marks_queued >> 1;
        marks_left   = marks_left - 1'b1;
        open_segment(kind);
    endfunction

    // Tone -> mark gap -> next mark, then letter gap, then idle
    function automatic void close_segment();
        if (seg_now == KEY_DOT || seg_now == KEY_DASH)
            open_segment(KEY_MARK_GAP);
        else if (marks_left != 0)
            next_mark();
        else if (letter_gap_due)
        begin
            letter_gap_due = 1'b0;
            open_segment(KEY_LETTER_GAP);
        end
        else
            open_segment(KEY_IDLE);
    endfunction

    // Tones end only on a carrier period boundary
    function automatic void key_tick();
        int unsigned span;
        logic [7:0]  half;
        if (seg_now == KEY_IDLE)
            return;
        span      = span_ticks(seg_now);
        half      = (carrier_setting == 0) ? 8'd1 : carrier_setting;
        seg_ticks = seg_ticks + 1'b1;
        if (seg_now == KEY_DOT || seg_now == KEY_DASH)
        begin
            half_count = half_count + 1'b1;
            if (half_count >= half)
            begin
                half_count = '0;
                if (seg_ticks >= span)
                begin
                    buzz_level = 1'b0;
                    close_segment();
                end
                else
                begin
                    buzz_level   = tone_on_next;
                    tone_on_next = ~tone_on_next;
                end
            end
        end
        else if (seg_ticks >= span)
            close_segment();
    endfunction

    // Apply one accepted beat and return the result beat it should produce
    function automatic out_t key_beat(input in_t b);
        out_t       o;
        logic       rej;
        logic [2:0] len;
        logic [4:0] dashes;
        rej = 1'b0;
        case (b.action) inside
            ACT_TICK:
                key_tick();
            ACT_LOAD, ACT_PHRASE:
            begin
                if (seg_now != KEY_IDLE)
                    rej = 1'b1;
                else if (b.action == ACT_PHRASE || b.character == CH_SPACE)
                begin
                    marks_left     = '0;
                    marks_queued   = '0;
                    letter_gap_due = (b.action == ACT_LOAD);
                    open_segment(KEY_WORD_GAP);
                end
                else if (morse_lookup(b.character, len, dashes))
                begin
                    marks_queued   = dashes;
                    marks_left     = len;
                    letter_gap_due = 1'b1;
                    next_mark();
                end
            end
            default:
                ;
        endcase
        o.buzzer   = buzz_level;
        o.busy_res = (seg_now != KEY_IDLE);
        o.rejected = rej;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic in_t beat_of(input logic [1:0] a, input logic [7:0] c);
        in_t b;
        b.action    = a;
        b.character = c;
        return b;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_t random_beat();
        return beat_of(2'($urandom_range(0, 3)), rand_byte());
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Offer one beat, wait for it to be taken, then record its expected result
    task automatic send_beat(input in_t b);
        int gap;
        gap = tx_steady ? 0 : pick_pause();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (b.action != ACT_IGNORED && (seg_now != KEY_IDLE || b.action == ACT_PHRASE ||
            (b.action == ACT_LOAD && is_keyable(b.character))))
            keyed_beats++;
        expected_beats.push_back(key_beat(b));
    endtask

    // Tick until the keyer is idle; noisy mixes in random beats while busy
    task automatic run_out(input bit noisy);
        while (seg_now != KEY_IDLE)
        begin
            if (noisy && $urandom_range(0, 14) == 0)
                send_beat(random_beat());
            else
                send_beat(beat_of(ACT_TICK, rand_byte()));
        end
    endtask

    task automatic key_out(input logic [1:0] a, input logic [7:0] ch, input bit noisy);
        send_beat(beat_of(a, ch));
        run_out(noisy);
    endtask

    // Stop offering and wait until every result beat is back
    task automatic drain();
        item_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Write both registers; upper byte of the carrier write is junk
    task automatic program_keyer(input logic [15:0] unit, input logic [7:0] carrier);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_UNIT_TICKS;
        cfg_data  <= unit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        unit_setting = unit;
        cfg_index <= CFG_CARRIER_TICKS;
        cfg_data  <= {rand_byte(), carrier};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        carrier_setting = carrier;
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Idle keyer: ticks, action 3 and codes outside the table change nothing
    task automatic test_idle_inputs();
        logic [7:0] odd_codes [9] = '{8'h00, 8'h1F, 8'h2F, 8'h3A, 8'h40,
                                      8'h5B, 8'h61, 8'h7A, 8'hFF};
        send_beat(beat_of(ACT_TICK, 8'h00));
        send_beat(beat_of(ACT_TICK, 8'hFF));
        send_beat(beat_of(ACT_IGNORED, CH_A));
        send_beat(beat_of(ACT_IGNORED, 8'hFF));
        foreach (odd_codes[i])
            send_beat(beat_of(ACT_LOAD, odd_codes[i]));
    endtask

    // Reset settings, rejects while busy, then a shorter unit mid-dash
    task automatic test_live_register_write();
        send_beat(beat_of(ACT_LOAD, "T"));
        repeat (5) send_beat(beat_of(ACT_TICK, rand_byte()));
        send_beat(beat_of(ACT_LOAD, CH_A));
        send_beat(beat_of(ACT_PHRASE, 8'h00));
        send_beat(beat_of(ACT_IGNORED, CH_Z));
        program_keyer(16'd1, 8'd1);
        run_out(1'b0);
    endtask

    // All dots, all dashes, single marks, word space and end of phrase
    task automatic test_element_shapes();
        program_keyer(16'd2, 8'd2);
        key_out(ACT_LOAD, "5", 1'b0);
        key_out(ACT_LOAD, CH_ZERO, 1'b0);
        key_out(ACT_LOAD, "E", 1'b0);
        key_out(ACT_LOAD, "T", 1'b0);
        send_beat(beat_of(ACT_LOAD, CH_SPACE));
        send_beat(beat_of(ACT_PHRASE, 8'hAA));
        run_out(1'b0);
        key_out(ACT_PHRASE, 8'h55, 1'b0);
    endtask

    // Widest carrier, zero settings, widest unit cut short while busy
    task automatic test_register_extremes();
        program_keyer(16'd1, 8'd255);
        key_out(ACT_LOAD, "E", 1'b0);
        program_keyer(16'd0, 8'd0);
        key_out(ACT_LOAD, "T", 1'b0);
        program_keyer(16'hFFFF, 8'd255);
        send_beat(beat_of(ACT_LOAD, CH_SPACE));
        repeat (4) send_beat(beat_of(ACT_TICK, rand_byte()));
        program_keyer(16'd3, 8'd2);
        run_out(1'b0);
    endtask

    // Receiver holds off long enough for the input side to stall
    task automatic test_output_backpressure();
        program_keyer(16'd1, 8'd1);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        wait (hold_active);
        key_out(ACT_LOAD, CH_ZERO, 1'b0);
        drain();
        tx_steady = 1'b0;
    endtask

    // Phases of random settings; mostly whole characters, some noise
    task automatic test_random_traffic();
        int unsigned goal;
        int          r;
        logic [15:0] unit;
        logic [7:0]  carrier;
        logic [7:0]  ch;
        for (int p = 0; p < PHASES; p++)
        begin
            r       = $urandom_range(0, 9);
            unit    = (p == 0 || r < 5) ? 16'd1 :
                      (r < 8) ? 16'($urandom_range(2, 4)) : 16'($urandom_range(5, 12));
            r       = $urandom_range(0, 9);
            carrier = (p == 0 || r < 5) ? 8'd1 :
                      (r < 8) ? 8'($urandom_range(2, 3)) : 8'($urandom_range(4, 8));
            program_keyer(unit, carrier);
            tx_steady = (p == 3);
            rx_steady = (p == 3);
            goal = keyed_beats + PHASE_ITEMS;
            while (keyed_beats < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    r  = $urandom_range(0, 40);
                    ch = (r < 10) ? 8'(CH_ZERO + r) :
                         (r < 36) ? 8'(CH_A + (r - 10)) :
                         (r == 36) ? CH_SPACE : rand_byte();
                    key_out(ACT_LOAD, ch, 1'b1);
                end
                else if (r < 85)
                    key_out(ACT_PHRASE, rand_byte(), 1'b1);
                else
                    repeat ($urandom_range(1, 4)) send_beat(random_beat());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random stall pattern, plus one long hold on request
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int   run;
        logic level;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req     = 1'b0;
                hold_active  = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_active  = 1'b0;
                result_stall <= 1'b0;
            end
            else if (rx_steady)
                result_stall <= 1'b0;
            else
            begin
                level = ($urandom_range(0, 99) < 35);
                run   = level ? pick_pause() : $urandom_range(1, 16);
                if (run < 1)
                    run = 1;
                result_stall <= level;
                repeat (run - 1) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result check and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else if (result_valid && !result_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result beat with none pending: buzzer=%0b busy=%0b rej=%0b",
                                 result.buzzer, result.busy_res, result.rejected);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.buzzer !== want.buzzer || result.busy_res !== want.busy_res ||
                        result.rejected !== want.rejected)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"mismatch at %0t: want buzzer=%0b busy=%0b rej=%0b,",
                                      " got buzzer=%0b busy=%0b rej=%0b"},
                                     $realtime, want.buzzer, want.busy_res, want.rejected,
                                     result.buzzer, result.busy_res, result.rejected);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        unit_setting    = 16'd100;
        carrier_setting = 8'd1;
        marks_queued    = '0;
        marks_left      = '0;
        letter_gap_due  = 1'b0;
        open_segment(KEY_IDLE);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_inputs();
        test_live_register_write();
        test_element_shapes();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
